>>> rtl/core/badr_pkg.sv
// Shared types and constants for the bus address decoder with internal RAM.
// Used by badr_decode and bus_address_decoder_with_ram_core; no dependencies.
package badr_pkg;

   // Target codes reported with every access.
   localparam logic [3:0] TGT_NONE      = 4'd0;
   localparam logic [3:0] TGT_BOOT_ROM  = 4'd1;
   localparam logic [3:0] TGT_CART_ROM  = 4'd2;
   localparam logic [3:0] TGT_VRAM      = 4'd3;
   localparam logic [3:0] TGT_CART_RAM  = 4'd4;
   localparam logic [3:0] TGT_WORK_RAM  = 4'd5;
   localparam logic [3:0] TGT_OAM       = 4'd6;
   localparam logic [3:0] TGT_IO_REG    = 4'd7;
   localparam logic [3:0] TGT_HIGH_RAM  = 4'd8;
   localparam logic [3:0] TGT_UNUSABLE  = 4'd9;
   localparam logic [3:0] TGT_IO_UNMAP  = 4'd10;

   // Where the read byte of an access comes from.
   localparam logic [1:0] SRC_CONST = 2'd0;
   localparam logic [1:0] SRC_WRAM  = 2'd1;
   localparam logic [1:0] SRC_HRAM  = 2'd2;

   // Access modes.
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // Region boundaries of the memory map.
   localparam logic [15:0] BOOT_ROM_END = 16'h0100;
   localparam logic [15:0] CART_ROM_END = 16'h8000;
   localparam logic [15:0] VRAM_END     = 16'hA000;
   localparam logic [15:0] CART_RAM_END = 16'hC000;
   localparam logic [15:0] WORK_RAM_END = 16'hFE00;
   localparam logic [15:0] OAM_END      = 16'hFEA0;
   localparam logic [15:0] IO_BASE      = 16'hFF00;
   localparam logic [15:0] HIGH_RAM_BASE = 16'hFF80;

   localparam logic [7:0] BYTE_OPEN_BUS = 8'hFF;
   localparam logic [7:0] BYTE_ZERO     = 8'h00;

   // I/O register presence, bit i for register index i.
   localparam logic [127:0] IO_READ_MASK  =
      128'h0000000000010FFF_FFFF007F56D780F7;
   localparam logic [127:0] IO_WRITE_MASK =
      128'h0000000000010FEF_FFFF007F7FDF80F7;

   // Decoded access, passed from the decoder to the pipeline.
   typedef struct packed {
      logic [3:0]  target;
      logic [15:0] offset;
      logic [7:0]  rdata;
      logic        rdata_valid;
      logic [1:0]  src;
      logic        wram_we;
      logic        hram_we;
   } dec_type;

endpackage

>>> rtl/core/badr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are not reset.
module badr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/badr_decode.sv
// Combinational address decoder: region, offset, constant read data and
// store strobes for one bus access. Depends on badr_pkg.
module badr_decode #(
   parameter int WORK_RAM_DEPTH = 8192,
   parameter int HIGH_RAM_DEPTH = 128
) (
   input  logic             mode,
   input  logic [15:0]      address,
   input  logic             dma_active,
   input  logic             boot_rom_disabled,
   input  logic             allow_dma,
   output badr_pkg::dec_type dec
);

   localparam int WR_AW = $clog2(WORK_RAM_DEPTH);
   localparam int HR_AW = $clog2(HIGH_RAM_DEPTH);
   localparam int WR_IW = (WR_AW < 13) ? WR_AW : 13;
   localparam int HR_IW = (HR_AW < 7) ? HR_AW : 7;

   logic             wr;
   logic [WR_AW-1:0] wr_idx;
   logic [HR_AW-1:0] hr_idx;
   logic             io_hit;

   // Store indexes with the echo mirror folded in.
   assign wr_idx = WR_AW'(address[WR_IW-1:0]);
   assign hr_idx = HR_AW'(address[HR_IW-1:0]);
   assign wr     = (mode == badr_pkg::MODE_WRITE);
   assign io_hit = wr ? badr_pkg::IO_WRITE_MASK[address[6:0]]
                      : badr_pkg::IO_READ_MASK[address[6:0]];

   // Region decode in priority order.
   always_comb begin
      dec             = '0;
      dec.src         = badr_pkg::SRC_CONST;
      dec.target      = badr_pkg::TGT_NONE;
      if (dma_active && (address < badr_pkg::IO_BASE) && !allow_dma) begin
         if (!wr) begin
            dec.rdata       = badr_pkg::BYTE_OPEN_BUS;
            dec.rdata_valid = 1'b1;
         end
      end else if (address < badr_pkg::CART_ROM_END) begin
         if ((address < badr_pkg::BOOT_ROM_END) && !boot_rom_disabled) begin
            if (!wr) begin
               dec.target = badr_pkg::TGT_BOOT_ROM;
               dec.offset = address;
            end
         end else begin
            dec.target = badr_pkg::TGT_CART_ROM;
            dec.offset = address;
         end
      end else if (address < badr_pkg::VRAM_END) begin
         dec.target = badr_pkg::TGT_VRAM;
         dec.offset = address;
      end else if (address < badr_pkg::CART_RAM_END) begin
         dec.target = badr_pkg::TGT_CART_RAM;
         dec.offset = address;
      end else if (address < badr_pkg::WORK_RAM_END) begin
         dec.target  = badr_pkg::TGT_WORK_RAM;
         dec.offset  = 16'(wr_idx);
         dec.wram_we = wr;
         if (!wr) begin
            dec.src         = badr_pkg::SRC_WRAM;
            dec.rdata_valid = 1'b1;
         end
      end else if (address < badr_pkg::OAM_END) begin
         dec.target = badr_pkg::TGT_OAM;
         dec.offset = address;
      end else if (address < badr_pkg::IO_BASE) begin
         dec.target = badr_pkg::TGT_UNUSABLE;
         if (!wr) begin
            dec.rdata       = badr_pkg::BYTE_ZERO;
            dec.rdata_valid = 1'b1;
         end
      end else if (address < badr_pkg::HIGH_RAM_BASE) begin
         dec.offset = 16'(address[6:0]);
         if (io_hit) begin
            dec.target = badr_pkg::TGT_IO_REG;
         end else begin
            dec.target = badr_pkg::TGT_IO_UNMAP;
            if (!wr) begin
               dec.rdata       = badr_pkg::BYTE_OPEN_BUS;
               dec.rdata_valid = 1'b1;
            end
         end
      end else begin
         dec.target  = badr_pkg::TGT_HIGH_RAM;
         dec.offset  = 16'(hr_idx);
         dec.hram_we = wr;
         if (!wr) begin
            dec.src         = badr_pkg::SRC_HRAM;
            dec.rdata_valid = 1'b1;
         end
      end
   end

endmodule

>>> rtl/core/bus_address_decoder_with_ram_core.sv
// Top level of the bus address decoder with internal work RAM and high RAM.
// Depends on badr_pkg, badr_decode and badr_ram.
//
//   Channel  Direction  Payload
//   req_*    in         tuser: mode; tdata: address, write_data, dma_active, boot_rom_disabled
//   rsp_*    out        tuser: target; tdata: target_offset, read_data, read_data_valid
//   csr_*    in         csr_wdata: allow_access_during_dma
//
// One access per cycle sustained while rsp_tready stays high; each result passes through
// the decode stage, where the RAM read is registered, and then the output register.
// Reset clears the pipeline valid bits and the DMA allow register; RAM
// contents stay undefined until written and need no clearing pass.
// A stalled result holds in the output register while one more access
// waits in the decode stage; input stalls only when both are full.
module bus_address_decoder_with_ram_core #(
   parameter int WORK_RAM_DEPTH = 8192,
   parameter int HIGH_RAM_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   // Access requests.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [15:0] address, [23:16] write_data,
                                   // [24] dma_active, [25] boot_rom_disabled
   input  logic        req_tuser,  // [0] mode
   // Decode results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [15:0] target_offset, [23:16] read_data,
                                   // [24] read_data_valid
   output logic [3:0]  rsp_tuser,  // [3:0] target
   // Configuration.
   input  logic        csr_we,
   input  logic        csr_wdata   // [0] allow_access_during_dma
);

   localparam int WR_AW = $clog2(WORK_RAM_DEPTH);
   localparam int HR_AW = $clog2(HIGH_RAM_DEPTH);

   badr_pkg::dec_type dec;

   logic        allow_ff, allow_in;
   logic        a_valid_ff, a_valid_in;
   logic [3:0]  a_target_ff;
   logic [15:0] a_offset_ff;
   logic [7:0]  a_rdata_ff;
   logic        a_rvalid_ff;
   logic [1:0]  a_src_ff;

   logic        out_valid_ff, out_valid_in;
   logic [3:0]  out_target_ff;
   logic [15:0] out_offset_ff;
   logic [7:0]  out_rdata_ff, out_rdata_in;
   logic        out_rvalid_ff;

   logic        accept;
   logic        out_free;
   logic        a_move;
   logic [7:0]  wram_rd_data;
   logic [7:0]  hram_rd_data;

   // Configuration register.
   assign allow_in = csr_we ? csr_wdata : allow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff <= 1'b0;
      end else begin
         allow_ff <= allow_in;
      end
   end

   // Address decode of the incoming access.
   badr_decode #(
      .WORK_RAM_DEPTH (WORK_RAM_DEPTH),
      .HIGH_RAM_DEPTH (HIGH_RAM_DEPTH)
   ) u_decode (
      .mode              (req_tuser),
      .address           (req_tdata[15:0]),
      .dma_active        (req_tdata[24]),
      .boot_rom_disabled (req_tdata[25]),
      .allow_dma         (allow_ff),
      .dec               (dec)
   );

   // Pipeline flow control.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign a_move     = a_valid_ff && out_free;
   assign req_tready = !a_valid_ff || a_move;
   assign accept     = req_tvalid && req_tready;

   // Internal stores, accessed at transfer time.
   badr_ram #(
      .WIDTH (8),
      .DEPTH (WORK_RAM_DEPTH)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (accept && dec.wram_we),
      .wr_addr (dec.offset[WR_AW-1:0]),
      .wr_data (req_tdata[23:16]),
      .rd_en   (accept && (dec.src == badr_pkg::SRC_WRAM)),
      .rd_addr (dec.offset[WR_AW-1:0]),
      .rd_data (wram_rd_data)
   );

   badr_ram #(
      .WIDTH (8),
      .DEPTH (HIGH_RAM_DEPTH)
   ) u_high_ram (
      .clock   (clock),
      .wr_en   (accept && dec.hram_we),
      .wr_addr (dec.offset[HR_AW-1:0]),
      .wr_data (req_tdata[23:16]),
      .rd_en   (accept && (dec.src == badr_pkg::SRC_HRAM)),
      .rd_addr (dec.offset[HR_AW-1:0]),
      .rd_data (hram_rd_data)
   );

   // Decode stage valid bit.
   assign a_valid_in = accept ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   // Decode stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         a_target_ff <= dec.target;
         a_offset_ff <= dec.offset;
         a_rdata_ff  <= dec.rdata;
         a_rvalid_ff <= dec.rdata_valid;
         a_src_ff    <= dec.src;
      end
   end

   // Read byte selection from the stores or the constant.
   always_comb begin
      case (a_src_ff)
         badr_pkg::SRC_WRAM: out_rdata_in = wram_rd_data;
         badr_pkg::SRC_HRAM: out_rdata_in = hram_rd_data;
         default:            out_rdata_in = a_rdata_ff;
      endcase
   end

   // Output register valid bit.
   assign out_valid_in = a_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (a_move) begin
         out_target_ff <= a_target_ff;
         out_offset_ff <= a_offset_ff;
         out_rdata_ff  <= out_rdata_in;
         out_rvalid_ff <= a_rvalid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_target_ff;
   assign rsp_tdata  = {7'd0, out_rvalid_ff, out_rdata_ff, out_offset_ff};

   // A stalled decode stage keeps its item.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !out_free) |=> a_valid_ff)
      else $error("decode stage lost an item while stalled");

   // Every transfer fills the decode stage.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      accept |=> a_valid_ff)
      else $error("accepted access not held in decode stage");

   // Store reads only come from the matching targets.
   a_src_tgt: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && (a_src_ff != badr_pkg::SRC_CONST)) |->
      (a_rvalid_ff && ((a_target_ff == badr_pkg::TGT_WORK_RAM) ||
                       (a_target_ff == badr_pkg::TGT_HIGH_RAM))))
      else $error("store read with wrong target");

   // Results without decoder data carry a zero byte.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_rvalid_ff) |-> (out_rdata_ff == 8'd0))
      else $error("read byte not zero while not settled");

endmodule

>>> tb/sv/bus_address_decoder_with_ram_core_tb.sv
// Self-checking testbench for bus_address_decoder_with_ram_core: directed region and DMA
// cases, then random traffic checked against a behavioral decoder with shadow RAMs.
// Depends on badr_pkg and the decoder RTL; needs no files or arguments.
`timescale 1ns / 1ps

module bus_address_decoder_with_ram_core_tb;

   localparam int WRAM_DEPTH  = 8192;
   localparam int HRAM_DEPTH  = 128;
   localparam int CYCLE_LIMIT = 500000;

   // I/O register presence per index, bit i for index i.
   localparam logic [127:0] IO_RD_PRESENT = {64'h0000000000010FFF, 64'hFFFF007F56D780F7};
   localparam logic [127:0] IO_WR_PRESENT = {64'h0000000000010FEF, 64'hFFFF007F7FDF80F7};

   typedef struct packed {
      logic        mode;
      logic [15:0] address;
      logic [7:0]  wdata;
      logic        dma;
      logic        boot_off;
   } bus_access_type;

   typedef struct packed {
      logic [3:0]  target;
      logic [15:0] offset;
      logic [7:0]  rdata;
      logic        rvalid;
   } decode_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;

   // Shadow copy of the decoder state.
   logic [7:0] wram_shadow [WRAM_DEPTH];
   logic [7:0] hram_shadow [HRAM_DEPTH];
   bit         wram_written [WRAM_DEPTH];
   bit         hram_written [HRAM_DEPTH];
   int         wram_used [$];
   int         hram_used [$];
   logic       dma_allow = 1'b0;

   decode_result_type pending_results [$];
   decode_result_type seen;
   decode_result_type want;

   int  cycle_count = 0;
   int  errors = 0;
   int  n_results = 0;
   int  n_reads = 0;
   int  n_writes = 0;
   int  n_blocked = 0;
   int  rsp_hold = 0;
   bit  idle_on = 1'b1;

   bus_address_decoder_with_ram_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Work out the result of one access and apply its store to the shadow RAMs.
   function automatic decode_result_type predict_decode(bus_access_type a);
      decode_result_type r;
      int idx;
      r = '0;
      if (a.dma && a.address < 16'hFF00 && !dma_allow) begin
         if (a.mode == badr_pkg::MODE_READ) begin
            r.rdata  = 8'hFF;
            r.rvalid = 1'b1;
         end
      end else if (a.address < 16'h8000) begin
         if (a.address < 16'h0100 && !a.boot_off) begin
            if (a.mode == badr_pkg::MODE_READ) begin
               r.target = badr_pkg::TGT_BOOT_ROM;
               r.offset = a.address;
            end
         end else begin
            r.target = badr_pkg::TGT_CART_ROM;
            r.offset = a.address;
         end
      end else if (a.address < 16'hA000) begin
         r.target = badr_pkg::TGT_VRAM;
         r.offset = a.address;
      end else if (a.address < 16'hC000) begin
         r.target = badr_pkg::TGT_CART_RAM;
         r.offset = a.address;
      end else if (a.address < 16'hFE00) begin
         idx = int'(a.address & 16'h1FFF) % WRAM_DEPTH;
         r.target = badr_pkg::TGT_WORK_RAM;
         r.offset = 16'(idx);
         if (a.mode == badr_pkg::MODE_WRITE) begin
            wram_shadow[idx] = a.wdata;
            if (!wram_written[idx]) wram_used.push_back(idx);
            wram_written[idx] = 1'b1;
         end else begin
            r.rdata  = wram_shadow[idx];
            r.rvalid = 1'b1;
         end
      end else if (a.address < 16'hFEA0) begin
         r.target = badr_pkg::TGT_OAM;
         r.offset = a.address;
      end else if (a.address < 16'hFF00) begin
         r.target = badr_pkg::TGT_UNUSABLE;
         if (a.mode == badr_pkg::MODE_READ) r.rvalid = 1'b1;
      end else if (a.address < 16'hFF80) begin
         idx = int'(a.address[6:0]);
         r.offset = 16'(idx);
         if ((a.mode == badr_pkg::MODE_WRITE) ? IO_WR_PRESENT[idx] : IO_RD_PRESENT[idx]) begin
            r.target = badr_pkg::TGT_IO_REG;
         end else begin
            r.target = badr_pkg::TGT_IO_UNMAP;
            if (a.mode == badr_pkg::MODE_READ) begin
               r.rdata  = 8'hFF;
               r.rvalid = 1'b1;
            end
         end
      end else begin
         idx = int'(a.address[6:0]) % HRAM_DEPTH;
         r.target = badr_pkg::TGT_HIGH_RAM;
         r.offset = 16'(idx);
         if (a.mode == badr_pkg::MODE_WRITE) begin
            hram_shadow[idx] = a.wdata;
            if (!hram_written[idx]) hram_used.push_back(idx);
            hram_written[idx] = 1'b1;
         end else begin
            r.rdata  = hram_shadow[idx];
            r.rvalid = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic bus_access_type make_access(logic mode, logic [15:0] address,
                                                  logic [7:0] wdata, logic dma,
                                                  logic boot_off);
      bus_access_type a;
      a.mode     = mode;
      a.address  = address;
      a.wdata    = wdata;
      a.dma      = dma;
      a.boot_off = boot_off;
      return a;
   endfunction

   // Random access weighted toward region edges, internal RAM and I/O space.
   function automatic bus_access_type random_access();
      bus_access_type a;
      int pick;
      int idx;
      pick       = $urandom_range(0, 99);
      a.mode     = $urandom_range(0, 1) ? badr_pkg::MODE_WRITE : badr_pkg::MODE_READ;
      a.wdata    = 8'($urandom_range(0, 255));
      a.dma      = ($urandom_range(0, 4) == 0);
      a.boot_off = 1'($urandom_range(0, 1));
      if (pick < 8)       a.address = 16'($urandom_range(16'h0000, 16'h01FF));
      else if (pick < 14) a.address = 16'($urandom_range(16'h0200, 16'h7FFF));
      else if (pick < 22) a.address = 16'($urandom_range(16'h8000, 16'hBFFF));
      else if (pick < 45) a.address = 16'($urandom_range(16'hC000, 16'hFDFF));
      else if (pick < 53) a.address = 16'($urandom_range(16'hFE00, 16'hFEFF));
      else if (pick < 75) a.address = 16'($urandom_range(16'hFF00, 16'hFF7F));
      else if (pick < 95) a.address = 16'($urandom_range(16'hFF80, 16'hFFFF));
      else                a.address = 16'($urandom);

      // Reads that reach an internal store are steered to entries that hold data.
      if (a.mode == badr_pkg::MODE_READ &&
          !(a.dma && a.address < 16'hFF00 && !dma_allow)) begin
         if (a.address >= 16'hFF80) begin
            idx = int'(a.address[6:0]) % HRAM_DEPTH;
            if (!hram_written[idx]) begin
               if (hram_used.size() == 0) a.mode = badr_pkg::MODE_WRITE;
               else a.address = 16'hFF80 |
                                16'(hram_used[$urandom_range(0, hram_used.size() - 1)]);
            end
         end else if (a.address >= 16'hC000 && a.address < 16'hFE00) begin
            idx = int'(a.address & 16'h1FFF) % WRAM_DEPTH;
            if (!wram_written[idx]) begin
               if (wram_used.size() == 0) begin
                  a.mode = badr_pkg::MODE_WRITE;
               end else begin
                  idx = wram_used[$urandom_range(0, wram_used.size() - 1)];
                  // Use the echo mirror for half of the redirected reads that it covers.
                  if (idx < 'h1E00 && $urandom_range(0, 1)) a.address = 16'hE000 + 16'(idx);
                  else a.address = 16'hC000 + 16'(idx);
               end
            end
         end
      end
      return a;
   endfunction

   // Send one access and record its expected result once the transfer happens.
   task automatic issue_access(input bus_access_type a);
      int gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, a.boot_off, a.dma, a.wdata, a.address};
      req_tuser  <= a.mode;
      do @(posedge clock); while (!req_tready);
      if (a.dma && a.address < 16'hFF00 && !dma_allow) n_blocked++;
      if (a.mode == badr_pkg::MODE_WRITE) n_writes++;
      else n_reads++;
      pending_results.push_back(predict_decode(a));
   endtask

   // Stop sending and wait until every outstanding result has come back.
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Write the allow register while the pipeline is empty.
   task automatic set_dma_allow(input logic value);
      pause_until_drained();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      dma_allow = value;
   endtask

   // Directed walk over every region boundary and the special cases.
   task automatic test_region_map();
      set_dma_allow(1'b0);
      // Boot ROM overlay and cartridge ROM.
      issue_access(make_access(badr_pkg::MODE_READ,  16'h0000, 8'h00, 1'b0, 1'b0));
      issue_access(make_access(badr_pkg::MODE_READ,  16'h00FF, 8'hFF, 1'b0, 1'b0));
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'h0050, 8'h5A, 1'b0, 1'b0));
      issue_access(make_access(badr_pkg::MODE_READ,  16'h00FF, 8'h00, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'h0100, 8'h12, 1'b0, 1'b0));
      issue_access(make_access(badr_pkg::MODE_READ,  16'h7FFF, 8'h00, 1'b0, 1'b1));
      // Video RAM and cartridge RAM.
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'h8000, 8'h34, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_READ,  16'hBFFF, 8'h00, 1'b0, 1'b1));
      // Work RAM, including writes and reads through the echo mirror.
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'hC000, 8'hFF, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'hE123, 8'hA5, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'hDDFF, 8'h00, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_READ,  16'hC000, 8'h00, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_READ,  16'hC123, 8'h00, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_READ,  16'hFDFF, 8'h00, 1'b0, 1'b1));
      // Sprite memory and the unusable area.
      issue_access(make_access(badr_pkg::MODE_READ,  16'hFE00, 8'h00, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_READ,  16'hFEA0, 8'h00, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'hFEFF, 8'h77, 1'b0, 1'b1));
      // I/O registers: present and absent reads, and an absent write.
      issue_access(make_access(badr_pkg::MODE_READ,  16'hFF00, 8'h00, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_READ,  16'hFF03, 8'h00, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'hFF7F, 8'h99, 1'b0, 1'b1));
      // High RAM at both ends.
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'hFF80, 8'h3C, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'hFFFF, 8'hC3, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_READ,  16'hFFFF, 8'h00, 1'b0, 1'b1));
      // DMA blocks reads and drops writes below the I/O page only.
      issue_access(make_access(badr_pkg::MODE_READ,  16'h1234, 8'h00, 1'b1, 1'b1));
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'hC000, 8'h55, 1'b1, 1'b1));
      issue_access(make_access(badr_pkg::MODE_READ,  16'hC000, 8'h00, 1'b0, 1'b1));
      issue_access(make_access(badr_pkg::MODE_READ,  16'hFF80, 8'h00, 1'b1, 1'b1));
   endtask

   // With the allow bit set, DMA no longer blocks the lower map.
   task automatic test_dma_allow();
      set_dma_allow(1'b1);
      issue_access(make_access(badr_pkg::MODE_READ,  16'h1234, 8'h00, 1'b1, 1'b1));
      issue_access(make_access(badr_pkg::MODE_WRITE, 16'hC001, 8'h77, 1'b1, 1'b1));
      issue_access(make_access(badr_pkg::MODE_READ,  16'hC001, 8'h00, 1'b1, 1'b1));
      issue_access(make_access(badr_pkg::MODE_READ,  16'hFEA0, 8'h00, 1'b1, 1'b1));
   endtask

   // Random traffic under one allow setting, with a full drain halfway through.
   task automatic test_random_traffic(input int count, input logic allow, input bit idle);
      set_dma_allow(allow);
      idle_on = idle;
      for (int k = 0; k < count; k++) begin
         if (k == count / 2) pause_until_drained();
         issue_access(random_access());
      end
   endtask

   // Result side: random stall drawn after each transfer.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) rsp_hold = idle_on ? $urandom_range(0, 17) : 0;
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result transfer with the oldest expected result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.target = rsp_tuser;
         seen.offset = rsp_tdata[15:0];
         seen.rdata  = rsp_tdata[23:16];
         seen.rvalid = rsp_tdata[24];
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 20)
               $display({"%0t: unexpected result, expected none, ",
                         "actual target %0d offset %h rdata %h valid %0d"},
                        $time, seen.target, seen.offset, seen.rdata, seen.rvalid);
         end else begin
            want = pending_results.pop_front();
            n_results++;
            if (seen !== want) begin
               errors++;
               if (errors <= 20)
                  $display({"%0t: mismatch, expected target %0d offset %h rdata %h ",
                            "valid %0d, actual target %0d offset %h rdata %h valid %0d"},
                           $time, want.target, want.offset, want.rdata, want.rvalid,
                           seen.target, seen.offset, seen.rdata, seen.rvalid);
            end
         end
      end
   end

   // Watchdog on the total run length.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
   end

   // Test sequence.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_region_map();
      test_dma_allow();
      test_random_traffic(500, 1'b0, 1'b1);
      test_random_traffic(400, 1'b1, 1'b1);
      test_random_traffic(300, 1'b0, 1'b0);
      test_random_traffic(300, 1'b1, 1'b0);
      idle_on = 1'b1;

      pause_until_drained();
      repeat (10) @(posedge clock);

      $display({"Sent %0d accesses (%0d reads, %0d writes, %0d blocked by DMA) ",
                "under both DMA allow settings."},
               n_reads + n_writes, n_reads, n_writes, n_blocked);
      $display("Checked %0d results; %0d errors.", n_results, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> bus_address_decoder_with_ram_core.f
rtl/core/badr_pkg.sv
rtl/core/badr_ram.sv
rtl/core/badr_decode.sv
rtl/core/bus_address_decoder_with_ram_core.sv
tb/sv/bus_address_decoder_with_ram_core_tb.sv
